/* rtl/pfc_pkg.sv */
// Shared types and constants for the pixel format converter.
// Used by pfc_core and pixel_format_converter; no dependencies.
`default_nettype none

package pfc_pkg;

  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned CfgWidth   = 3;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned IndexWidth = 2;

  // register indexes
  localparam logic [IndexWidth-1:0] RegSourceDepth  = 2'd0;
  localparam logic [IndexWidth-1:0] RegTargetFormat = 2'd1;

  // target formats
  localparam logic [CfgWidth-1:0] FmtGray      = 3'd0;
  localparam logic [CfgWidth-1:0] FmtGrayAlpha = 3'd1;
  localparam logic [CfgWidth-1:0] FmtRgb       = 3'd2;
  localparam logic [CfgWidth-1:0] FmtRgba      = 3'd3;
  localparam logic [CfgWidth-1:0] FmtRed       = 3'd4;
  localparam logic [CfgWidth-1:0] FmtGreen     = 3'd5;
  localparam logic [CfgWidth-1:0] FmtBlue      = 3'd6;
  localparam logic [CfgWidth-1:0] FmtAlpha     = 3'd7;

  // source depths
  localparam logic [CfgWidth-1:0] DepthGray      = 3'd1;
  localparam logic [CfgWidth-1:0] DepthGrayAlpha = 3'd2;
  localparam logic [CfgWidth-1:0] DepthRgba      = 3'd4;

  localparam logic [CfgWidth-1:0] ResetSourceDepth  = DepthRgba;
  localparam logic [CfgWidth-1:0] ResetTargetFormat = FmtRgba;

  // BT.709 luma weights, unsigned Q16; they sum to 65536
  localparam logic [15:0] LumaWr = 16'd13933;
  localparam logic [15:0] LumaWg = 16'd46871;
  localparam logic [15:0] LumaWb = 16'd4732;

  localparam logic [ChanWidth-1:0] Opaque = 8'd255;

  localparam logic [CountWidth-1:0] Count1 = 3'd1;
  localparam logic [CountWidth-1:0] Count2 = 3'd2;
  localparam logic [CountWidth-1:0] Count3 = 3'd3;
  localparam logic [CountWidth-1:0] Count4 = 3'd4;

  typedef struct packed {
    logic [ChanWidth-1:0] chan0;
    logic [ChanWidth-1:0] chan1;
    logic [ChanWidth-1:0] chan2;
    logic [ChanWidth-1:0] chan3;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanWidth-1:0]  out0;
    logic [ChanWidth-1:0]  out1;
    logic [ChanWidth-1:0]  out2;
    logic [ChanWidth-1:0]  out3;
    logic [CountWidth-1:0] out_count;
  } pixel_out_t;

endpackage

`default_nettype wire

/* rtl/pfc_core.sv */
// Combinational conversion of one pixel: channel unpack, luma, target select.
// Depends on pfc_pkg.
`default_nettype none

module pfc_core (
  input  wire pfc_pkg::pixel_in_t                    pix,
  input  wire logic [pfc_pkg::CfgWidth-1:0]          source_depth,
  input  wire logic [pfc_pkg::CfgWidth-1:0]          target_format,
  output pfc_pkg::pixel_out_t                        result
);

  logic                             gray_src;
  logic [pfc_pkg::ChanWidth-1:0]    r, g, b, a, y;
  logic [23:0]                      prod_r, prod_g, prod_b;
  logic [25:0]                      luma_sum;

  // depth 0 counts as gray, 5..7 as rgba
  assign gray_src = (source_depth <= pfc_pkg::DepthGrayAlpha);

  assign prod_r   = 24'(pix.chan0) * 24'(pfc_pkg::LumaWr);
  assign prod_g   = 24'(pix.chan1) * 24'(pfc_pkg::LumaWg);
  assign prod_b   = 24'(pix.chan2) * 24'(pfc_pkg::LumaWb);
  assign luma_sum = {2'b00, prod_r} + {2'b00, prod_g} + {2'b00, prod_b};

  always_comb begin
    r = pix.chan0;
    g = gray_src ? pix.chan0 : pix.chan1;
    b = gray_src ? pix.chan0 : pix.chan2;
    y = gray_src ? pix.chan0 : luma_sum[23:16];
    if (source_depth == pfc_pkg::DepthGrayAlpha) begin
      a = pix.chan1;
    end else if (source_depth >= pfc_pkg::DepthRgba) begin
      a = pix.chan3;
    end else begin
      a = pfc_pkg::Opaque;
    end
  end

  always_comb begin
    result = '0;
    case (target_format)
      pfc_pkg::FmtGray: begin
        result.out0      = y;
        result.out_count = pfc_pkg::Count1;
      end
      pfc_pkg::FmtGrayAlpha: begin
        result.out0      = y;
        result.out1      = a;
        result.out_count = pfc_pkg::Count2;
      end
      pfc_pkg::FmtRgb: begin
        result.out0      = r;
        result.out1      = g;
        result.out2      = b;
        result.out_count = pfc_pkg::Count3;
      end
      pfc_pkg::FmtRgba: begin
        result.out0      = r;
        result.out1      = g;
        result.out2      = b;
        result.out3      = a;
        result.out_count = pfc_pkg::Count4;
      end
      pfc_pkg::FmtRed: begin
        result.out0      = r;
        result.out_count = pfc_pkg::Count1;
      end
      pfc_pkg::FmtGreen: begin
        result.out0      = g;
        result.out_count = pfc_pkg::Count1;
      end
      pfc_pkg::FmtBlue: begin
        result.out0      = b;
        result.out_count = pfc_pkg::Count1;
      end
      default: begin
        result.out0      = a;
        result.out_count = pfc_pkg::Count1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pixel_format_converter.sv */
// Pixel format converter: input register, conversion logic, result register.
// An accepted pixel passes through the input register, then the result register, to result valid.
// Throughput: one pixel per cycle while out_ready holds; an empty input stage still accepts during a stall.
// Reset (rst, synchronous): pipeline emptied, source_depth 4, target_format rgba.
// Depends on pfc_pkg and pfc_core.
`default_nettype none

module pixel_format_converter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire pfc_pkg::pixel_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output pfc_pkg::pixel_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [pfc_pkg::IndexWidth-1:0]      cfg_index,
  input  wire logic [pfc_pkg::CfgWidth-1:0]        cfg_data
);

  logic [pfc_pkg::CfgWidth-1:0] source_depth;
  logic [pfc_pkg::CfgWidth-1:0] target_format;
  logic                         s1_valid;
  pfc_pkg::pixel_in_t           s1_pix;
  pfc_pkg::pixel_out_t          result_next;
  logic                         out_load;

  // result register takes a word when empty or being drained
  assign out_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_depth  <= pfc_pkg::ResetSourceDepth;
      target_format <= pfc_pkg::ResetTargetFormat;
    end else if (cfg_we) begin
      if (cfg_index == pfc_pkg::RegSourceDepth) begin
        source_depth <= cfg_data;
      end else if (cfg_index == pfc_pkg::RegTargetFormat) begin
        target_format <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pix <= in_data;
    end
  end

  pfc_core u_core (
    .pix           (s1_pix),
    .source_depth  (source_depth),
    .target_format (target_format),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_data <= result_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_count == pfc_pkg::Count1 ||
                   out_data.out_count == pfc_pkg::Count2 ||
                   out_data.out_count == pfc_pkg::Count3 ||
                   out_data.out_count == pfc_pkg::Count4))
    else $error("out_count out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_count == pfc_pkg::Count1) |->
      (out_data.out1 == '0 && out_data.out2 == '0 && out_data.out3 == '0))
    else $error("unused result bytes not zero");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word lost in input stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> out_valid)
    else $error("input stage word not moved to result register");

endmodule

`default_nettype wire
